### hdl/box_smoothing_filter_macros.svh
// ----------------------------------------------------------------------------
// Box smoothing filter assertion macros
// Property templates for the assertions of the filter datapath.
// ----------------------------------------------------------------------------
`ifndef BOX_SMOOTHING_FILTER_MACROS_SVH
`define BOX_SMOOTHING_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define BSF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box filter assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define BSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box filter assertion failed");

`endif

### hdl/bsf_pkg.sv
// ----------------------------------------------------------------------------
// Box smoothing filter package
// Shared constants and the command and status types between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bsf_pkg;

  localparam int MAX_RADIUS_DEF  = 31;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int RADIUS_BITS     = 5;

  typedef struct packed {
    logic accept;
    logic upd;
    logic fupd;
    logic div_start;
    logic clear;
  } bsf_cmd_t;

  typedef struct packed {
    logic emit_step;
    logic emit_flush;
    logic flush_last;
    logic fin;
    logic final_flag;
    logic div_done;
  } bsf_sts_t;

endpackage

`default_nettype wire

### hdl/bsf_ram.sv
// ----------------------------------------------------------------------------
// Box smoothing filter RAM
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/bsf_dp.sv
// ----------------------------------------------------------------------------
// Box smoothing filter datapath
// Radius register, sample ring, running window sum and a restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_smoothing_filter_macros.svh"

module bsf_dp import bsf_pkg::*; #(
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [RADIUS_BITS-1:0]        cfg_wdata,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          final_sample,
  input  wire bsf_cmd_t                      cmd,
  output bsf_sts_t                           sts,
  output logic signed [SAMPLE_BITS-1:0]      smoothed,
  output logic                               final_result
);

  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int AW  = RW + 1;
  localparam int CW  = $clog2(MAX_RADIUS + 2);
  localparam int SW  = SAMPLE_BITS + AW;
  localparam int DCW = $clog2(SW);

  logic [RW-1:0]                 rad;
  logic [RW-1:0]                 rad_wr;
  logic [AW-1:0]                 win;
  logic [CW-1:0]                 rad_p1;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;
  logic [AW-1:0]                 k;
  logic [AW-1:0]                 k_sat;
  logic [RW-1:0]                 t;
  logic [RW-1:0]                 t_new;
  logic [AW-1:0]                 wptr;
  logic [AW-1:0]                 raddr;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic                          fin_reg;
  logic signed [SAMPLE_BITS-1:0] first_value;
  logic signed [SAMPLE_BITS-1:0] leave;
  logic signed [SW-1:0]          sum;
  logic signed [SW-1:0]          sum_step;
  logic signed [SW-1:0]          init_sum;
  logic [SW-1:0]                 sum_mag;
  logic                          div_busy;
  logic [DCW-1:0]                div_cnt;
  logic [SW-1:0]                 dvd;
  logic [AW-1:0]                 rem;
  logic [SW-1:0]                 quot;
  logic                          neg;
  logic [AW:0]                   shifted;
  logic [AW:0]                   diff;
  logic                          ge;
  logic [AW-1:0]                 rem_next;
  logic [SW-1:0]                 q_next;
  logic [SAMPLE_BITS-1:0]        q_low;

  always_comb begin
    if (cfg_wdata == '0) begin
      rad_wr = RW'(1);
    end else if (int'(cfg_wdata) > MAX_RADIUS) begin
      rad_wr = RW'(MAX_RADIUS);
    end else begin
      rad_wr = RW'(cfg_wdata);
    end
  end

  assign win    = {rad, 1'b1};
  assign rad_p1 = CW'(rad) + CW'(1);
  assign raddr  = wptr - win;

  bsf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (1 << AW)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wptr),
    .wdata (sample),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Samples older than the array start read as the first sample.
  assign leave    = (k >= win) ? rd_data : first_value;
  assign sum_step = sum + SW'(x_reg) - SW'(leave);
  assign init_sum = SW'($signed(x_reg) * $signed({1'b0, win}));

  always_comb begin
    if (count == '0) begin
      count_next = CW'(1);
    end else if (count == rad_p1) begin
      count_next = count;
    end else begin
      count_next = count + CW'(1);
    end
  end

  assign k_sat = (k == win) ? k : k + AW'(1);
  assign t_new = t + RW'(1);

  assign shifted  = {rem, dvd[SW-1]};
  assign ge       = shifted >= {1'b0, win};
  assign diff     = shifted - {1'b0, win};
  assign rem_next = ge ? diff[AW-1:0] : shifted[AW-1:0];
  assign q_next   = {quot[SW-2:0], ge};
  assign q_low    = q_next[SAMPLE_BITS-1:0];
  assign sum_mag  = sum[SW-1] ? $unsigned(-sum) : $unsigned(sum);

  assign sts.emit_step  = count_next == rad_p1;
  assign sts.emit_flush = (count == rad_p1) ||
                          ((CW+1)'(t_new) + (CW+1)'(count) >= (CW+1)'(rad_p1));
  assign sts.flush_last = t_new == rad;
  assign sts.fin        = fin_reg;
  assign sts.final_flag = final_result;
  assign sts.div_done   = div_busy && (div_cnt == DCW'(SW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      rad         <= RW'(1);
      count       <= '0;
      k           <= '0;
      t           <= '0;
      sum         <= '0;
      first_value <= '0;
      wptr        <= '0;
      div_busy    <= 1'b0;
      div_cnt     <= '0;
    end else begin
      if (cfg_we || cmd.clear) begin
        count       <= '0;
        k           <= '0;
        t           <= '0;
        sum         <= '0;
        first_value <= '0;
        if (cfg_we) begin
          rad <= rad_wr;
        end
      end else if (cmd.upd) begin
        if (count == '0) begin
          first_value <= x_reg;
          sum         <= init_sum;
          k           <= AW'(1);
        end else begin
          sum <= sum_step;
          k   <= k_sat;
        end
        count <= count_next;
        wptr  <= wptr + AW'(1);
      end else if (cmd.fupd) begin
        sum  <= sum_step;
        k    <= k_sat;
        t    <= t_new;
        wptr <= wptr + AW'(1);
      end
      if (cmd.div_start) begin
        div_busy <= 1'b1;
        div_cnt  <= '0;
      end else if (div_busy) begin
        div_cnt <= div_cnt + DCW'(1);
        if (sts.div_done) begin
          div_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_reg   <= sample;
      fin_reg <= final_sample;
    end
    if (cmd.upd) begin
      final_result <= 1'b0;
    end else if (cmd.fupd) begin
      final_result <= sts.flush_last;
    end
    if (cmd.div_start) begin
      dvd  <= sum_mag;
      rem  <= '0;
      quot <= '0;
      neg  <= sum[SW-1];
    end else if (div_busy) begin
      dvd  <= {dvd[SW-2:0], 1'b0};
      rem  <= rem_next;
      quot <= q_next;
      if (sts.div_done) begin
        smoothed <= neg ? -q_low : q_low;
      end
    end
  end

  `BSF_ASSERT_IMP(a_count_bound, 1'b1, count <= rad_p1)
  `BSF_ASSERT_IMP(a_hist_bound, 1'b1, k <= win)
  `BSF_ASSERT_IMP(a_flush_bound, 1'b1, t <= rad)
  `BSF_ASSERT_NEXT(a_div_runs, cmd.div_start, div_busy && !sts.div_done)

endmodule

`default_nettype wire

### hdl/bsf_ctrl.sv
// ----------------------------------------------------------------------------
// Box smoothing filter controller
// Sequences sample update, end-of-array flush steps, division and output.
// ----------------------------------------------------------------------------
`default_nettype none

module bsf_ctrl import bsf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     sample_valid,
  output logic          sample_stall,
  output logic          result_valid,
  input  wire logic     result_stall,
  output bsf_cmd_t      cmd,
  input  wire bsf_sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_FREAD = 3'd2;
  localparam logic [2:0] S_FUPD  = 3'd3;
  localparam logic [2:0] S_DLOAD = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign sample_stall = state != S_IDLE;
  assign result_valid = state == S_OUT;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.accept = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (sts.emit_step) begin
          state_next = S_DLOAD;
        end else if (sts.fin) begin
          state_next = S_FREAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FREAD: begin
        state_next = S_FUPD;
      end
      S_FUPD: begin
        cmd.fupd = 1'b1;
        if (sts.emit_flush) begin
          state_next = S_DLOAD;
        end else if (sts.flush_last) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_FREAD;
        end
      end
      S_DLOAD: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!result_stall) begin
          if (sts.final_flag) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else if (sts.fin) begin
            state_next = S_FREAD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hdl/box_smoothing_filter.sv
// An accepted request is stored, then updates the window sum; when it gives a result,
// the bit-serial divider is loaded and run, and the result is held until it is taken.
// No new request is accepted until the previous one and any flush it starts are done;
// each end-of-array flush step reads the ring, updates the sum and may give a result.
// Reset is synchronous: radius returns to 1 and the array state clears; no memory sweep.
// ----------------------------------------------------------------------------
// Box smoothing filter
// Moving average over a clamped window of 2r+1 samples, one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module box_smoothing_filter import bsf_pkg::*; #(
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [RADIUS_BITS-1:0]        cfg_wdata,
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          final_sample,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0]      smoothed,
  output logic                               final_result
);

  bsf_cmd_t cmd;
  bsf_sts_t sts;

  bsf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  bsf_dp #(
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample       (sample),
    .final_sample (final_sample),
    .cmd          (cmd),
    .sts          (sts),
    .smoothed     (smoothed),
    .final_result (final_result)
  );

endmodule

`default_nettype wire
